FILE: sv/dust_sensor_average_classify_defines.svh
// Assertion macros for the dust sensor averaging block.
// Used by the top level only; expects clk and rst_n in scope.
`ifndef DUST_SENSOR_AVERAGE_CLASSIFY_DEFINES_SVH
`define DUST_SENSOR_AVERAGE_CLASSIFY_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define DSAC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define DSAC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/dsac_pkg.sv
// Shared constants, codes and types for the dust sensor averaging block.
// No dependencies.
`default_nettype none

package dsac_pkg;

    localparam int WINDOW     = 10;
    localparam int SAMPLE_W   = 16;
    localparam int SUM_W      = SAMPLE_W + $clog2(WINDOW);
    localparam int SCALE_W    = 4;
    localparam int BASE_W     = 16;
    localparam int OFFSET_W   = 8;
    localparam int LIMIT_W    = 16;
    localparam int MV_W       = SCALE_W + SAMPLE_W;
    localparam int DENS_W     = 18;
    localparam int LEVEL_W    = 3;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int MIDQ_DEPTH = 4;
    localparam int OUTQ_DEPTH = 4;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MV_SCALE       = 3'd0,
        REG_NO_DUST_MV     = 3'd1,
        REG_DENSITY_OFFSET = 3'd2,
        REG_GOOD_LIMIT     = 3'd3,
        REG_NORMAL_LIMIT   = 3'd4,
        REG_BAD_LIMIT      = 3'd5
    } cfg_reg_e;

    typedef enum logic [LEVEL_W-1:0] {
        LEVEL_WAIT   = 3'd0,
        LEVEL_GOOD   = 3'd1,
        LEVEL_NORMAL = 3'd2,
        LEVEL_BAD    = 3'd3,
        LEVEL_DANGER = 3'd4
    } level_e;

    typedef struct packed {
        logic [SCALE_W-1:0]  mv_scale;
        logic [BASE_W-1:0]   no_dust_mv;
        logic [OFFSET_W-1:0] density_offset;
        logic [LIMIT_W-1:0]  good_limit;
        logic [LIMIT_W-1:0]  normal_limit;
        logic [LIMIT_W-1:0]  bad_limit;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        mv_scale:       4'd1,
        no_dust_mv:     16'd400,
        density_offset: 8'd50,
        good_limit:     16'd15,
        normal_limit:   16'd50,
        bad_limit:      16'd100
    };

    // Window sum handed from the front to the middle queue.
    typedef struct packed {
        logic             push;
        logic [SUM_W-1:0] sum;
    } sum_push_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_stat_t;

endpackage

`default_nettype wire

FILE: sv/dust_sensor_average_classify.sv
// Dust sensor moving average and density classifier, one sample per cycle
// while full is low. A sample word is taken whenever push is high and full is
// low; results leave in order through a small queue (empty/pop). Throughput is
// one word per clock while full is low, as the front part updates the window
// sum on each accepted word. The window sum enters the middle queue at the
// accepting edge, then passes six back stages (average, millivolts, baseline,
// divide by five, offset clamp, class), then the result queue write. The first
// sample after reset fills the whole ten-entry window. Configuration registers
// are written through cfg_we/cfg_index/cfg_data; the user must do so only while
// no sample is in flight, as the block itself does not enforce it.
`default_nettype none
`include "dust_sensor_average_classify_defines.svh"

module dust_sensor_average_classify (
    input  wire                             clk,
    input  wire                             rst_n,
    input  wire                             push,
    output logic                            full,
    input  wire  [dsac_pkg::SAMPLE_W-1:0]   sample,
    output logic                            empty,
    input  wire                             pop,
    output logic [dsac_pkg::SAMPLE_W-1:0]   average,
    output logic [dsac_pkg::DENS_W-1:0]     density,
    output logic [dsac_pkg::LEVEL_W-1:0]    level,
    input  wire                             cfg_we,
    input  wire  [dsac_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire  [dsac_pkg::CFG_DATA_W-1:0] cfg_data
);
    import dsac_pkg::*;

    cfg_t             cfg_reg;
    sum_push_t        to_q;
    queue_stat_t      mid_stat;
    logic [SUM_W-1:0] mid_sum;
    logic             mid_pop;

    // Register file; unknown indexes drop the word, upper data bits are cut.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= CFG_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_MV_SCALE:       cfg_reg.mv_scale       <= cfg_data[SCALE_W-1:0];
                REG_NO_DUST_MV:     cfg_reg.no_dust_mv     <= cfg_data[BASE_W-1:0];
                REG_DENSITY_OFFSET: cfg_reg.density_offset <= cfg_data[OFFSET_W-1:0];
                REG_GOOD_LIMIT:     cfg_reg.good_limit     <= cfg_data[LIMIT_W-1:0];
                REG_NORMAL_LIMIT:   cfg_reg.normal_limit   <= cfg_data[LIMIT_W-1:0];
                REG_BAD_LIMIT:      cfg_reg.bad_limit      <= cfg_data[LIMIT_W-1:0];
                default:            cfg_reg                <= cfg_reg;
            endcase
        end
    end

    dsac_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .sample (sample),
        .q_full (mid_stat.full),
        .to_q   (to_q)
    );

    dsac_queue u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .wr     (to_q),
        .rd_pop (mid_pop),
        .rd_sum (mid_sum),
        .stat   (mid_stat)
    );

    dsac_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .mid_sum   (mid_sum),
        .mid_empty (mid_stat.empty),
        .mid_pop   (mid_pop),
        .pop       (pop),
        .empty     (empty),
        .average   (average),
        .density   (density),
        .level     (level)
    );

    assign full = mid_stat.full;

    `DSAC_ASSERT_NOW(a_wait_iff_zero, !empty, (density == '0) == (level == LEVEL_WAIT), "wait class")
    `DSAC_ASSERT_NOW(a_dens_needs_avg, !empty && (density != '0), average != '0, "zero average")
    `DSAC_ASSERT_NEXT(a_accept_queued, push && !full, !mid_stat.empty, "accepted word lost")

endmodule

`default_nettype wire

FILE: sv/dsac_front.sv
// Front part: sample window as a shift line and the running window sum.
// Depends on dsac_pkg.
`default_nettype none

module dsac_front (
    input  wire                           clk,
    input  wire                           rst_n,
    input  wire                           push,
    input  wire  [dsac_pkg::SAMPLE_W-1:0] sample,
    input  wire                           q_full,
    output dsac_pkg::sum_push_t           to_q
);
    import dsac_pkg::*;

    logic [SAMPLE_W-1:0] win_reg [WINDOW];
    logic [SUM_W-1:0]    sum_reg;
    logic [SUM_W-1:0]    sum_next;
    logic                primed_reg;
    logic                accept;

    assign accept = push && !q_full;

    // First word fills the whole window, so the sum is sample times depth.
    always_comb
    begin
        if (primed_reg)
        begin
            sum_next = sum_reg - SUM_W'(win_reg[WINDOW-1]) + SUM_W'(sample);
        end
        else
        begin
            sum_next = SUM_W'(SUM_W'(sample) * SUM_W'(WINDOW));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg    <= '0;
            primed_reg <= 1'b0;
        end
        else if (accept)
        begin
            sum_reg    <= sum_next;
            primed_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            for (int i = 0; i < WINDOW; i++)
            begin
                if (!primed_reg)
                begin
                    win_reg[i] <= sample;
                end
                else if (i == 0)
                begin
                    win_reg[i] <= sample;
                end
                else
                begin
                    win_reg[i] <= win_reg[i-1];
                end
            end
        end
    end

    assign to_q.push = accept;
    assign to_q.sum  = sum_next;

endmodule

`default_nettype wire

FILE: sv/dsac_queue.sv
// Short queue of window sums between the front and back parts.
// Depends on dsac_pkg.
`default_nettype none

module dsac_queue (
    input  wire                        clk,
    input  wire                        rst_n,
    input  wire dsac_pkg::sum_push_t   wr,
    input  wire                        rd_pop,
    output logic [dsac_pkg::SUM_W-1:0] rd_sum,
    output dsac_pkg::queue_stat_t      stat
);
    import dsac_pkg::*;

    localparam int PTR_W = $clog2(MIDQ_DEPTH);
    localparam int CNT_W = $clog2(MIDQ_DEPTH + 1);

    logic [SUM_W-1:0] mem_reg [MIDQ_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             do_wr;
    logic             do_rd;

    assign stat.full  = (cnt_reg == CNT_W'(MIDQ_DEPTH));
    assign stat.empty = (cnt_reg == '0);
    assign do_wr      = wr.push && !stat.full;
    assign do_rd      = rd_pop && !stat.empty;
    assign rd_sum     = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (do_wr)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(MIDQ_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_rd)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(MIDQ_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_wr && !do_rd)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else if (do_rd && !do_wr)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr.sum;
        end
    end

endmodule

`default_nettype wire

FILE: sv/dsac_back.sv
// Back part: average, millivolt scaling, density, class, and result queue.
// Depends on dsac_pkg.
`default_nettype none

module dsac_back (
    input  wire                           clk,
    input  wire                           rst_n,
    input  wire dsac_pkg::cfg_t           cfg,
    input  wire  [dsac_pkg::SUM_W-1:0]    mid_sum,
    input  wire                           mid_empty,
    output logic                          mid_pop,
    input  wire                           pop,
    output logic                          empty,
    output logic [dsac_pkg::SAMPLE_W-1:0] average,
    output logic [dsac_pkg::DENS_W-1:0]   density,
    output logic [dsac_pkg::LEVEL_W-1:0]  level
);
    import dsac_pkg::*;

    // Divide by the window depth as a multiply by a rounded-up reciprocal.
    localparam int AVG_SHIFT   = SUM_W + $clog2(WINDOW);
    localparam int AVG_RECIP_W = AVG_SHIFT + 1 - $clog2(WINDOW);
    localparam int AVG_PROD_W  = SUM_W + AVG_RECIP_W;
    localparam logic [AVG_RECIP_W-1:0] AVG_RECIP =
        AVG_RECIP_W'((2**AVG_SHIFT + WINDOW - 1) / WINDOW);

    // Density is millivolts above baseline divided by five, then less the offset.
    localparam int DENS_DIVISOR = 5;
    localparam int Q_SHIFT      = MV_W + $clog2(DENS_DIVISOR);
    localparam int Q_RECIP_W    = Q_SHIFT + 1 - $clog2(DENS_DIVISOR);
    localparam int Q_PROD_W     = MV_W + Q_RECIP_W;
    localparam logic [Q_RECIP_W-1:0] Q_RECIP =
        Q_RECIP_W'((2**Q_SHIFT + DENS_DIVISOR - 1) / DENS_DIVISOR);

    localparam int PTR_W = $clog2(OUTQ_DEPTH);
    localparam int CNT_W = $clog2(OUTQ_DEPTH + 1);

    logic                  v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg;
    logic                  advance;
    logic                  oq_full;
    logic                  oq_push;
    logic                  oq_pop;

    logic [AVG_PROD_W-1:0] avg_prod;
    logic [Q_PROD_W-1:0]   q_prod;
    logic [MV_W-1:0]       base_ext;
    level_e                level_next;

    logic [SAMPLE_W-1:0]   s1_avg_reg;
    logic [SAMPLE_W-1:0]   s2_avg_reg;
    logic [MV_W-1:0]       s2_mv_reg;
    logic [SAMPLE_W-1:0]   s3_avg_reg;
    logic [MV_W-1:0]       s3_diff_reg;
    logic                  s3_below_reg;
    logic [SAMPLE_W-1:0]   s4_avg_reg;
    logic [DENS_W-1:0]     s4_q_reg;
    logic [SAMPLE_W-1:0]   s5_avg_reg;
    logic [DENS_W-1:0]     s5_dens_reg;
    logic [SAMPLE_W-1:0]   s6_avg_reg;
    logic [DENS_W-1:0]     s6_dens_reg;
    level_e                s6_level_reg;

    logic [SAMPLE_W-1:0]   oq_avg_reg   [OUTQ_DEPTH];
    logic [DENS_W-1:0]     oq_dens_reg  [OUTQ_DEPTH];
    level_e                oq_level_reg [OUTQ_DEPTH];
    logic [PTR_W-1:0]      wr_ptr_reg;
    logic [PTR_W-1:0]      rd_ptr_reg;
    logic [CNT_W-1:0]      cnt_reg;

    // Hold the whole pipeline only while the last stage cannot drain.
    assign oq_full = (cnt_reg == CNT_W'(OUTQ_DEPTH));
    assign advance = !(v6_reg && oq_full);
    assign mid_pop = advance && !mid_empty;
    assign oq_push = v6_reg && !oq_full;
    assign oq_pop  = pop && !empty;

    assign avg_prod = AVG_PROD_W'(mid_sum) * AVG_PROD_W'(AVG_RECIP);
    assign q_prod   = Q_PROD_W'(s3_diff_reg) * Q_PROD_W'(Q_RECIP);
    assign base_ext = MV_W'(cfg.no_dust_mv);

    // Zero density is always wait; limits are tested in order.
    always_comb
    begin
        if (s5_dens_reg == '0)
        begin
            level_next = LEVEL_WAIT;
        end
        else if (s5_dens_reg <= DENS_W'(cfg.good_limit))
        begin
            level_next = LEVEL_GOOD;
        end
        else if (s5_dens_reg <= DENS_W'(cfg.normal_limit))
        begin
            level_next = LEVEL_NORMAL;
        end
        else if (s5_dens_reg <= DENS_W'(cfg.bad_limit))
        begin
            level_next = LEVEL_BAD;
        end
        else
        begin
            level_next = LEVEL_DANGER;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
        end
        else if (advance)
        begin
            v1_reg <= mid_pop;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
            v6_reg <= v5_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s1_avg_reg   <= avg_prod[AVG_SHIFT +: SAMPLE_W];

            s2_avg_reg   <= s1_avg_reg;
            s2_mv_reg    <= MV_W'(cfg.mv_scale) * MV_W'(s1_avg_reg);

            s3_avg_reg   <= s2_avg_reg;
            s3_below_reg <= (s2_mv_reg < base_ext);
            s3_diff_reg  <= s2_mv_reg - base_ext;

            s4_avg_reg   <= s3_avg_reg;
            s4_q_reg     <= s3_below_reg ? '0 : q_prod[Q_SHIFT +: DENS_W];

            s5_avg_reg   <= s4_avg_reg;
            if (s4_q_reg > DENS_W'(cfg.density_offset))
            begin
                s5_dens_reg <= s4_q_reg - DENS_W'(cfg.density_offset);
            end
            else
            begin
                s5_dens_reg <= '0;
            end

            s6_avg_reg   <= s5_avg_reg;
            s6_dens_reg  <= s5_dens_reg;
            s6_level_reg <= level_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (oq_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(OUTQ_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (oq_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(OUTQ_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (oq_push && !oq_pop)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else if (oq_pop && !oq_push)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (oq_push)
        begin
            oq_avg_reg[wr_ptr_reg]   <= s6_avg_reg;
            oq_dens_reg[wr_ptr_reg]  <= s6_dens_reg;
            oq_level_reg[wr_ptr_reg] <= s6_level_reg;
        end
    end

    assign empty   = (cnt_reg == '0);
    assign average = oq_avg_reg[rd_ptr_reg];
    assign density = oq_dens_reg[rd_ptr_reg];
    assign level   = oq_level_reg[rd_ptr_reg];

endmodule

`default_nettype wire
